FILE: hdl/owsm_pkg.sv
package owsm_pkg;

    localparam int TIME_W    = 10;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    // action codes on the input channel
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_RESET   = 3'd1;
    localparam logic [2:0] ACT_WR_BIT  = 3'd2;
    localparam logic [2:0] ACT_RD_BIT  = 3'd3;
    localparam logic [2:0] ACT_WR_BYTE = 3'd4;
    localparam logic [2:0] ACT_RD_BYTE = 3'd5;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRES_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WR0_LOW   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WR1_LOW   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RD_LOW    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RD_WAIT   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RD_TAIL   = 3'd7;

    // fixed write recovery times
    localparam logic [TIME_W-1:0] REC_ZERO_US = 10'd90;
    localparam logic [TIME_W-1:0] REC_ONE_US  = 10'd30;

    localparam logic [3:0] BITS_ONE  = 4'd1;
    localparam logic [3:0] BITS_BYTE = 4'd8;

    typedef enum logic [1:0] {
        CLS_TICK   = 2'd0,
        CLS_CMD    = 2'd1,
        CLS_IGNORE = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        CMD_RESET   = 3'd0,
        CMD_WR_BIT  = 3'd1,
        CMD_RD_BIT  = 3'd2,
        CMD_WR_BYTE = 3'd3,
        CMD_RD_BYTE = 3'd4
    } cmd_t;

    typedef struct packed {
        cls_t       cls;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       level;
    } item_t;

    // first member lands in the top bits
    typedef struct packed {
        logic       rejected;
        logic       presence;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_TAIL = 9'b000001000,
        PH_WR_LOW   = 9'b000010000,
        PH_WR_REC   = 9'b000100000,
        PH_RD_LOW   = 9'b001000000,
        PH_RD_WAIT  = 9'b010000000,
        PH_RD_TAIL  = 9'b100000000
    } phase_t;

    function automatic logic [TIME_W-1:0] reg_default(input logic [REG_IDX_W-1:0] idx);
        logic [TIME_W-1:0] val;
        unique case (idx)
            REG_RESET_LOW:  val = 10'd500;
            REG_PRES_WAIT:  val = 10'd70;
            REG_RESET_TAIL: val = 10'd420;
            REG_WR0_LOW:    val = 10'd90;
            REG_WR1_LOW:    val = 10'd10;
            REG_RD_LOW:     val = 10'd2;
            REG_RD_WAIT:    val = 10'd11;
            REG_RD_TAIL:    val = 10'd47;
            default:        val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/owsm_front.sv
module owsm_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    output logic              push,
    output owsm_pkg::item_t   push_item,
    input  logic              queue_full
);
    import owsm_pkg::*;

    always_comb begin
        push_item.tx_byte = s_tdata[7:0];
        push_item.level   = s_tdata[8];
        push_item.cls     = CLS_CMD;
        push_item.cmd     = CMD_RESET;
        unique case (s_tuser)
            ACT_TICK:    push_item.cls = CLS_TICK;
            ACT_RESET:   push_item.cmd = CMD_RESET;
            ACT_WR_BIT:  push_item.cmd = CMD_WR_BIT;
            ACT_RD_BIT:  push_item.cmd = CMD_RD_BIT;
            ACT_WR_BYTE: push_item.cmd = CMD_WR_BYTE;
            ACT_RD_BYTE: push_item.cmd = CMD_RD_BYTE;
            default:     push_item.cls = CLS_IGNORE;
        endcase
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

endmodule

FILE: hdl/owsm_queue.sv
module owsm_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  owsm_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output owsm_pkg::item_t head_item
);
    import owsm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/owsm_back.sv
module owsm_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [owsm_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [owsm_pkg::TIME_W-1:0]        cfg_data,
    input  logic                               item_valid,
    input  owsm_pkg::item_t                    item,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output owsm_pkg::res_t                     m_res
);
    import owsm_pkg::*;

    logic [TIME_W-1:0] cfg_reg [NUM_REGS];

    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] cnt_reg, cnt_next;
    logic [3:0]        bits_reg, bits_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        rx_reg, rx_next;
    logic              pres_reg, pres_next;
    logic              rd_byte_reg, rd_byte_next;

    logic              m_valid_reg;
    res_t              m_res_reg, m_res_next;

    logic              done;
    logic              rej;

    assign pop      = item_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_res    = m_res_reg;

    always_comb begin
        logic [TIME_W-1:0] cnt_dec;
        logic [3:0]        bits_dec;
        logic [7:0]        shift_dec;

        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        rx_next      = rx_reg;
        pres_next    = pres_reg;
        rd_byte_next = rd_byte_reg;
        done         = 1'b0;
        rej          = 1'b0;
        cnt_dec      = (cnt_reg != '0) ? cnt_reg - 1'b1 : '0;
        bits_dec     = bits_reg - 1'b1;
        shift_dec    = shift_reg >> 1;

        if (pop) begin
            unique case (item.cls)
                CLS_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0) begin
                            unique case (phase_reg)
                                PH_RST_LOW: begin
                                    phase_next = PH_RST_WAIT;
                                    cnt_next   = cfg_reg[REG_PRES_WAIT];
                                end
                                PH_RST_WAIT: begin
                                    pres_next  = !item.level;
                                    phase_next = PH_RST_TAIL;
                                    cnt_next   = cfg_reg[REG_RESET_TAIL];
                                end
                                PH_RST_TAIL: begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                end
                                PH_WR_LOW: begin
                                    phase_next = PH_WR_REC;
                                    cnt_next   = shift_reg[0] ? REC_ONE_US : REC_ZERO_US;
                                end
                                PH_WR_REC: begin
                                    shift_next = shift_dec;
                                    bits_next  = bits_dec;
                                    if (bits_dec != '0) begin
                                        phase_next = PH_WR_LOW;
                                        cnt_next   = shift_dec[0] ? cfg_reg[REG_WR1_LOW]
                                                                  : cfg_reg[REG_WR0_LOW];
                                    end else begin
                                        phase_next = PH_IDLE;
                                        done       = 1'b1;
                                    end
                                end
                                PH_RD_LOW: begin
                                    phase_next = PH_RD_WAIT;
                                    cnt_next   = cfg_reg[REG_RD_WAIT];
                                end
                                PH_RD_WAIT: begin
                                    // byte reads shift in from the top, LSB first
                                    rx_next    = rd_byte_reg ? {item.level, rx_reg[7:1]}
                                                             : {7'd0, item.level};
                                    phase_next = PH_RD_TAIL;
                                    cnt_next   = cfg_reg[REG_RD_TAIL];
                                end
                                PH_RD_TAIL: begin
                                    bits_next = bits_dec;
                                    if (bits_dec != '0) begin
                                        phase_next = PH_RD_LOW;
                                        cnt_next   = cfg_reg[REG_RD_LOW];
                                    end else begin
                                        phase_next = PH_IDLE;
                                        done       = 1'b1;
                                    end
                                end
                                default: begin
                                    phase_next = PH_IDLE;
                                    cnt_next   = '0;
                                end
                            endcase
                        end
                    end
                end
                CLS_CMD: begin
                    if (phase_reg != PH_IDLE) begin
                        rej = 1'b1;
                    end else begin
                        rd_byte_next = (item.cmd == CMD_RD_BYTE);
                        unique case (item.cmd)
                            CMD_RESET: begin
                                pres_next  = 1'b0;
                                phase_next = PH_RST_LOW;
                                cnt_next   = cfg_reg[REG_RESET_LOW];
                            end
                            CMD_WR_BIT: begin
                                shift_next = {7'd0, item.tx_byte[0]};
                                bits_next  = BITS_ONE;
                                phase_next = PH_WR_LOW;
                                cnt_next   = item.tx_byte[0] ? cfg_reg[REG_WR1_LOW]
                                                             : cfg_reg[REG_WR0_LOW];
                            end
                            CMD_RD_BIT: begin
                                rx_next    = '0;
                                bits_next  = BITS_ONE;
                                phase_next = PH_RD_LOW;
                                cnt_next   = cfg_reg[REG_RD_LOW];
                            end
                            CMD_WR_BYTE: begin
                                shift_next = item.tx_byte;
                                bits_next  = BITS_BYTE;
                                phase_next = PH_WR_LOW;
                                cnt_next   = item.tx_byte[0] ? cfg_reg[REG_WR1_LOW]
                                                             : cfg_reg[REG_WR0_LOW];
                            end
                            CMD_RD_BYTE: begin
                                rx_next    = '0;
                                bits_next  = BITS_BYTE;
                                phase_next = PH_RD_LOW;
                                cnt_next   = cfg_reg[REG_RD_LOW];
                            end
                            default: ;
                        endcase
                    end
                end
                CLS_IGNORE: ;
                default: ;
            endcase
        end

        m_res_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                               || (phase_next == PH_RD_LOW);
        m_res_next.busy_res  = (phase_next != PH_IDLE);
        m_res_next.done_res  = done;
        m_res_next.rx_byte   = rx_next;
        m_res_next.presence  = pres_next;
        m_res_next.rejected  = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= reg_default(REG_IDX_W'(i));
            end
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            bits_reg    <= '0;
            shift_reg   <= '0;
            rx_reg      <= '0;
            pres_reg    <= 1'b0;
            rd_byte_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            bits_reg    <= bits_next;
            shift_reg   <= shift_next;
            rx_reg      <= rx_next;
            pres_reg    <= pres_next;
            rd_byte_reg <= rd_byte_next;
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_res_reg <= m_res_next;
        end
    end

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.done_res |-> !m_res_reg.busy_res && !m_res_reg.drive_low)
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && item.cls == CLS_CMD && phase_reg != PH_IDLE |=> m_res_reg.rejected)
        else $error("command while busy not rejected");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && item.cls == CLS_TICK && phase_reg == PH_IDLE |=>
            phase_reg == PH_IDLE && $stable(rx_reg) && $stable(pres_reg))
        else $error("idle tick changed state");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= BITS_BYTE)
        else $error("bit count out of range");

    a_hold_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> $stable(phase_reg) && $stable(cnt_reg))
        else $error("slot state moved without an item");

endmodule

FILE: hdl/one_wire_slot_master_unit.sv
// 1-Wire slot master.
// Input channel s_*: one item per microsecond tick (tuser = 0, tdata[8] = sampled bus level)
// or a command (tuser 1 reset/presence, 2 write bit, 3 read bit, 4 write byte, 5 read byte;
// tdata[7:0] = byte to send). Codes 6 and 7 are ignored but still answered.
// Result channel m_*: exactly one result item per input item, in order, carrying the bus
// drive, busy, done pulse, received byte, presence flag and a reject flag for commands
// that arrive while a slot sequence runs.
// Config port: cfg_we/cfg_index/cfg_data write the eight 10-bit timing registers;
// write only while no command is running.
// Throughput is one item per clock while m_tready is high. An accepted item passes
// through the QUEUE_DEPTH-entry queue and then the slot engine, whose result lands in
// the output register. The engine updates its whole state once per item.
// When m_tready is low the output register holds and the queue fills; s_tready drops
// once the queue is full, so nothing is lost.
// Reset (aresetn low, synchronous): timing registers return to their defaults, the
// engine goes idle with presence and received byte cleared, queue and output empty.
module one_wire_slot_master_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] bus_level, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                   // [10:3] rx_byte, [11] presence, [12] rejected
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import owsm_pkg::*;

    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  pop;
    logic  queue_valid;
    item_t head_item;
    res_t  res;

    owsm_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    owsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_valid),
        .head_item (head_item)
    );

    owsm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (queue_valid),
        .item       (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res)
    );

    assign m_tdata = {3'd0, res};

endmodule
